// ===== design/mgm_pkg.sv =====
// Shared types and constants for the median-of-group then mean unit.
// No dependencies.
package mgm_pkg;

    localparam int MAX_GROUP_DEF = 128;
    localparam int SIZE_W        = 8;
    localparam int COUNT_W       = 16;
    localparam int SAMPLE_W      = 16;
    localparam int SUM_W         = 32;
    localparam int DIV_STEPS     = SUM_W;

    localparam logic [7:0]  GROUP_SIZE_RST  = 8'd9;
    localparam logic [15:0] GROUP_COUNT_RST = 16'd1;

    // register index, taken from paddr[2]
    localparam logic REG_GROUP_SIZE  = 1'b0;
    localparam logic REG_GROUP_COUNT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAND_RD,
        S_CAND_LD,
        S_SCAN,
        S_CHECK,
        S_MED_OUT,
        S_DIV,
        S_MEAN_OUT
    } t_state;

    typedef struct packed {
        logic write;
        logic cand_rd;
        logic cand_ld;
        logic scan;
        logic check;
        logic div_start;
        logic div_step;
        logic sel_mean;
        logic clear_run;
    } t_cmd;

    typedef struct packed {
        logic group_done;
        logic scan_done;
        logic found;
        logic run_end;
        logic div_done;
    } t_sts;

endpackage

// ===== design/mgm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mgm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mgm_ctrl.sv =====
// Sequencer for the median-of-group then mean unit.
// Depends on mgm_pkg; drives mgm_dpath through t_cmd and reads t_sts.
module mgm_ctrl
    import mgm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.write = 1'b1;
                    if (i_sts.group_done) n_state = S_CAND_RD;
                end
            end
            S_CAND_RD: begin
                o_cmd.cand_rd = 1'b1;
                n_state = S_CAND_LD;
            end
            S_CAND_LD: begin
                o_cmd.cand_ld = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state = i_sts.found ? S_MED_OUT : S_CAND_RD;
            end
            S_MED_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (i_sts.run_end) begin
                        o_cmd.div_start = 1'b1;
                        n_state = S_DIV;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_MEAN_OUT;
            end
            S_MEAN_OUT: begin
                o_valid = 1'b1;
                o_cmd.sel_mean = 1'b1;
                if (i_ready) begin
                    o_cmd.clear_run = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready while result pending");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped on stall");
    a_scan_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.scan_done) |=> r_state == S_CHECK)
        else $error("scan did not end in check");
    a_div_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_done) |=> r_state == S_MEAN_OUT)
        else $error("divide did not end in mean");
`endif

endmodule

// ===== design/mgm_dpath.sv =====
// Datapath: sample store, rank-select median search, median sum, serial divider.
// Depends on mgm_pkg and mgm_ram.
module mgm_dpath
    import mgm_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    input  logic [SIZE_W-1:0]          i_group_size,
    input  logic [COUNT_W-1:0]         i_group_count,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic signed [SAMPLE_W-1:0] o_value
);

    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam logic [SIZE_W-1:0] MAXG = SIZE_W'(MAX_GROUP);
    localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS);

    logic [SIZE_W-1:0]          r_sample_index;
    logic [COUNT_W-1:0]         r_group_index;
    logic signed [SUM_W-1:0]    r_median_sum;
    logic [SIZE_W-1:0]          r_n;
    logic [SIZE_W-1:0]          r_cand_i;
    logic signed [SAMPLE_W-1:0] r_cand_val;
    logic [SIZE_W-1:0]          r_scan_j;
    logic [SIZE_W-1:0]          r_jd;
    logic                       r_sv;
    logic [SIZE_W-1:0]          r_rank;
    logic signed [SAMPLE_W-1:0] r_med;
    logic [SUM_W-1:0]           r_dvd;
    logic [COUNT_W-1:0]         r_rem;
    logic [COUNT_W-1:0]         r_den;
    logic                       r_neg;
    logic [5:0]                 r_dcnt;

    logic [SIZE_W-1:0]          size_eff;
    logic [COUNT_W-1:0]         count_eff;
    logic [SIZE_W-1:0]          pos;
    logic [AW-1:0]              raddr;
    logic signed [SAMPLE_W-1:0] rdata;
    logic                       below;
    logic [COUNT_W:0]           trial;
    logic                       take;
    logic [SUM_W-1:0]           quo;

    always_comb begin
        size_eff = i_group_size;
        if (size_eff == '0) size_eff = SIZE_W'(1);
        if (size_eff > MAXG) size_eff = MAXG;
        count_eff = (i_group_count == '0) ? COUNT_W'(1) : i_group_count;
        pos = (r_sample_index >= size_eff) ? size_eff - SIZE_W'(1) : r_sample_index;
    end

    assign raddr = i_cmd.cand_rd ? r_cand_i[AW-1:0] : r_scan_j[AW-1:0];

    mgm_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_GROUP), .AW(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.write),
        .i_waddr(pos[AW-1:0]),
        .i_wdata(i_sample),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // rank with ties broken by store position
    assign below = (rdata < r_cand_val) || (rdata == r_cand_val && r_jd < r_cand_i);

    assign trial = {r_rem, r_dvd[SUM_W-1]};
    assign take  = trial >= {1'b0, r_den};
    assign quo   = r_neg ? (~r_dvd + SUM_W'(1)) : r_dvd;

    always_comb begin
        o_sts.group_done = ({1'b0, pos} + 9'd1) >= {1'b0, size_eff};
        o_sts.scan_done  = !r_sv && (r_scan_j == r_n);
        o_sts.found      = r_rank == (r_n >> 1);
        o_sts.run_end    = r_group_index >= count_eff;
        o_sts.div_done   = r_dcnt == DIV_LAST;
    end

    assign o_value = i_cmd.sel_mean ? quo[SAMPLE_W-1:0] : r_med;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_index <= '0;
            r_group_index  <= '0;
            r_median_sum   <= '0;
            r_sv           <= 1'b0;
            r_dcnt         <= '0;
        end else begin
            if (i_cmd.write) begin
                r_n      <= size_eff;
                r_cand_i <= '0;
                r_sample_index <= o_sts.group_done ? '0 : pos + SIZE_W'(1);
            end
            if (i_cmd.cand_ld) begin
                r_cand_val <= rdata;
                r_scan_j   <= '0;
                r_rank     <= '0;
                r_sv       <= 1'b0;
            end
            if (i_cmd.scan) begin
                // issue one read per cycle and count on the read data once it is registered
                r_sv <= r_scan_j < r_n;
                r_jd <= r_scan_j;
                if (r_scan_j < r_n) r_scan_j <= r_scan_j + SIZE_W'(1);
                if (r_sv && below) r_rank <= r_rank + SIZE_W'(1);
            end
            if (i_cmd.check) begin
                if (o_sts.found) begin
                    r_med         <= r_cand_val;
                    r_median_sum  <= r_median_sum + SUM_W'(r_cand_val);
                    r_group_index <= r_group_index + COUNT_W'(1);
                end else begin
                    r_cand_i <= r_cand_i + SIZE_W'(1);
                end
            end
            if (i_cmd.div_start) begin
                r_neg  <= r_median_sum[SUM_W-1];
                r_dvd  <= r_median_sum[SUM_W-1] ? (~r_median_sum + SUM_W'(1))
                                                 : r_median_sum;
                r_rem  <= '0;
                r_den  <= count_eff;
                r_dcnt <= '0;
            end
            if (i_cmd.div_step && !o_sts.div_done) begin
                r_rem  <= take ? COUNT_W'(trial - {1'b0, r_den}) : trial[COUNT_W-1:0];
                r_dvd  <= {r_dvd[SUM_W-2:0], take};
                r_dcnt <= r_dcnt + 6'd1;
            end
            if (i_cmd.clear_run) begin
                r_group_index <= '0;
                r_median_sum  <= '0;
            end
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.check |-> r_cand_i < r_n) else $error("candidate beyond group");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_run |=> (r_median_sum == '0 && r_group_index == '0))
        else $error("run not cleared");
    a_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> r_rank <= r_n) else $error("rank overflow");
`endif

endmodule

// ===== design/median_of_group_then_mean_unit.sv =====
// Top level: APB register file, sequencer and datapath of the median/mean unit.
// Depends on mgm_pkg, mgm_ctrl, mgm_dpath (and mgm_ram below it).
//
// Input channel i_valid/o_ready carries one signed sample per item; o_ready
// is high only while the unit is idle. Output channel o_valid/i_ready carries
// o_value with o_kind (0 median, 1 mean) and o_last (set on the mean).
// A sample that does not complete a group is stored and the unit is ready
// again the next cycle. When a group of N samples completes, the
// median is found by ranking each stored sample against the whole group,
// one store read per cycle, ending at the first sample whose rank is N/2.
// After the last group of a run a 32-step serial divide (one quotient bit
// per cycle) forms the mean once the median is taken. A stalled receiver
// holds the result, and no sample is taken until every result of the
// current item is delivered.
// Reset clears the run state and loads group_size 9, group_count 1; the
// sample store needs no clearing. Registers: 0x0 group_size, 0x4 group_count.
module median_of_group_then_mean_unit
    import mgm_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_value,
    output logic                       o_kind,
    output logic                       o_last
);

    logic [SIZE_W-1:0]  r_group_size;
    logic [COUNT_W-1:0] r_group_count;
    t_cmd cmd;
    t_sts sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size  <= GROUP_SIZE_RST;
            r_group_count <= GROUP_COUNT_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_GROUP_SIZE:  r_group_size  <= pwdata[SIZE_W-1:0];
                REG_GROUP_COUNT: r_group_count <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_GROUP_SIZE:  prdata = {24'd0, r_group_size};
            REG_GROUP_COUNT: prdata = {16'd0, r_group_count};
            default:         prdata = '0;
        endcase
    end

    mgm_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    mgm_dpath #(.MAX_GROUP(MAX_GROUP)) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_group_size (r_group_size),
        .i_group_count(r_group_count),
        .i_sample     (i_sample),
        .o_value      (o_value)
    );

    assign o_kind = cmd.sel_mean;
    assign o_last = cmd.sel_mean;

endmodule
